/* rtl/core/csth_pkg.sv */
package csth_pkg;

  localparam int MAX_STEPS_DEF   = 1000;
  localparam int VALUE_WIDTH_DEF = 64;

  localparam int CMD_W      = 2;
  localparam int START_W    = 31;
  localparam int INDEX_W    = 10;
  localparam int STEPS_W    = 10;
  localparam int BIN_W      = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USED_W = STEPS_W + 2 + BIN_W;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;
  localparam int UPC_W      = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_RUN   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MAP,
    OP_RD_CNT,
    OP_INC_WR,
    OP_RD_IDX,
    OP_LOAD_BIN,
    OP_CLR_WR,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_RUN_GO,
    CND_OVER,
    CND_SWEEP,
    CND_IS_RUN,
    CND_IS_READ,
    CND_IS_CLEAR
  } cond_t;

  typedef struct packed {
    op_t              op;
    hold_t            hold;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } dp_cmd_t;

  typedef struct packed {
    logic run_go;
    logic cnt_over;
    logic sweep_more;
    logic is_run;
    logic is_read;
    logic is_clear;
    logic out_busy;
  } dp_flags_t;

  localparam logic [UPC_W-1:0] UA_SWEEP    = 4'd0;
  localparam logic [UPC_W-1:0] UA_IDLE     = 4'd1;
  localparam logic [UPC_W-1:0] UA_DISP_RUN = 4'd2;
  localparam logic [UPC_W-1:0] UA_DISP_RD  = 4'd3;
  localparam logic [UPC_W-1:0] UA_DISP_CLR = 4'd4;
  localparam logic [UPC_W-1:0] UA_DISP_ANY = 4'd5;
  localparam logic [UPC_W-1:0] UA_RUN      = 4'd6;
  localparam logic [UPC_W-1:0] UA_RUN_RD   = 4'd7;
  localparam logic [UPC_W-1:0] UA_RUN_WR   = 4'd8;
  localparam logic [UPC_W-1:0] UA_RD       = 4'd9;
  localparam logic [UPC_W-1:0] UA_RD_LD    = 4'd10;
  localparam logic [UPC_W-1:0] UA_CLR      = 4'd11;
  localparam logic [UPC_W-1:0] UA_EMIT     = 4'd12;

  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      UA_SWEEP:    w = '{OP_CLR_WR,   HOLD_NONE, CND_SWEEP,    UA_SWEEP};
      UA_IDLE:     w = '{OP_ACCEPT,   HOLD_IN,   CND_NONE,     UA_IDLE};
      UA_DISP_RUN: w = '{OP_NOP,      HOLD_NONE, CND_IS_RUN,   UA_RUN};
      UA_DISP_RD:  w = '{OP_NOP,      HOLD_NONE, CND_IS_READ,  UA_RD};
      UA_DISP_CLR: w = '{OP_NOP,      HOLD_NONE, CND_IS_CLEAR, UA_CLR};
      UA_DISP_ANY: w = '{OP_NOP,      HOLD_NONE, CND_ALWAYS,   UA_EMIT};
      UA_RUN:      w = '{OP_MAP,      HOLD_NONE, CND_RUN_GO,   UA_RUN};
      UA_RUN_RD:   w = '{OP_RD_CNT,   HOLD_NONE, CND_OVER,     UA_EMIT};
      UA_RUN_WR:   w = '{OP_INC_WR,   HOLD_NONE, CND_ALWAYS,   UA_EMIT};
      UA_RD:       w = '{OP_RD_IDX,   HOLD_NONE, CND_NONE,     UA_RD};
      UA_RD_LD:    w = '{OP_LOAD_BIN, HOLD_NONE, CND_ALWAYS,   UA_EMIT};
      UA_CLR:      w = '{OP_CLR_WR,   HOLD_NONE, CND_SWEEP,    UA_CLR};
      UA_EMIT:     w = '{OP_EMIT,     HOLD_OUT,  CND_ALWAYS,   UA_IDLE};
      default:     w = '{OP_NOP,      HOLD_NONE, CND_ALWAYS,   UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/collatz_stopping_time_histogram_unit.sv */
// Collatz stopping-time histogram. Each command word on s_* gives exactly one
// result word on m_*. A run does one Collatz step per cycle, set by the step
// loop of the microprogram; a clear sweeps the bin memory one bin a cycle.
// After reset the same sweep zeroes the bins while s_tready stays low.
// One command is worked at a time; the next is taken once the result is
// registered, while that result still waits on m_tready.
module collatz_stopping_time_histogram_unit #(
  parameter int MAX_STEPS   = csth_pkg::MAX_STEPS_DEF,
  parameter int VALUE_WIDTH = csth_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // start_value, bin_index
  input  logic [csth_pkg::IN_DATA_W-1:0]  s_tdata,
  // command
  input  logic [csth_pkg::CMD_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // steps_taken, was_counted, overflowed, bin_value
  output logic [csth_pkg::OUT_DATA_W-1:0] m_tdata
);
  import csth_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  csth_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  csth_dp #(
    .MAX_STEPS   (MAX_STEPS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .flags    (flags),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready held after a command word was taken");

  a_sweep_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready)
    else $error("command taken before the bin sweep");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[STEPS_W] && m_tdata[STEPS_W+1]))
    else $error("run both counted and overflowed");

  a_counted_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[STEPS_W]) |-> (m_tdata[STEPS_W+2 +: BIN_W] != '0))
    else $error("counted run reports an empty bin");
`endif

endmodule

/* rtl/core/csth_seq.sv */
module csth_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  csth_pkg::dp_flags_t flags,
  output csth_pkg::dp_cmd_t   cmd
);
  import csth_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  uword_t           w;
  logic             stall;
  logic             take;

  always_comb begin
    w     = ucode(upc);
    stall = ((w.hold == HOLD_IN) && !s_tvalid) || ((w.hold == HOLD_OUT) && flags.out_busy);
    case (w.cond)
      CND_NONE:     take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_RUN_GO:   take = flags.run_go;
      CND_OVER:     take = flags.cnt_over;
      CND_SWEEP:    take = flags.sweep_more;
      CND_IS_RUN:   take = flags.is_run;
      CND_IS_READ:  take = flags.is_read;
      CND_IS_CLEAR: take = flags.is_clear;
      default:      take = 1'b0;
    endcase
    if (stall) begin
      upc_next = upc;
    end else if (take) begin
      upc_next = w.target;
    end else begin
      upc_next = upc + 1'b1;
    end
    cmd.op   = w.op;
    cmd.fire = !stall;
    s_tready = (w.hold == HOLD_IN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_SWEEP;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

/* rtl/core/csth_dp.sv */
module csth_dp #(
  parameter int MAX_STEPS   = csth_pkg::MAX_STEPS_DEF,
  parameter int VALUE_WIDTH = csth_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  csth_pkg::dp_cmd_t               cmd,
  output csth_pkg::dp_flags_t             flags,
  input  logic [csth_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [csth_pkg::CMD_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [csth_pkg::OUT_DATA_W-1:0] m_tdata
);
  import csth_pkg::*;

  localparam int NUM_BINS = MAX_STEPS + 1;
  localparam int CNT_W    = $clog2(MAX_STEPS + 2);
  localparam int AW       = $clog2(NUM_BINS);
  localparam int VW       = VALUE_WIDTH;

  localparam logic [VW-1:0]    VAL_ONE   = VW'(1);
  localparam logic [VW-1:0]    ODD_LIMIT = ({VW{1'b1}} - VAL_ONE) / 3;
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_STEPS);
  localparam logic [CNT_W-1:0] OVER_CNT  = CNT_W'(MAX_STEPS + 1);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(NUM_BINS - 1);

  logic [BIN_W-1:0] mem [NUM_BINS];

  logic [VW-1:0]      n;
  logic [CNT_W-1:0]   cnt;
  logic               ovf;
  logic               counted;
  logic [BIN_W-1:0]   binv;
  cmd_t               cmd_r;
  logic [INDEX_W-1:0] idx;
  logic [AW-1:0]      sweep;
  logic [BIN_W-1:0]   rdata;
  logic               out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  logic [VW-1:0]    n3;
  logic             idx_ok;
  logic [BIN_W-1:0] inc;
  logic             mem_re;
  logic [AW-1:0]    mem_ra;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [BIN_W-1:0] mem_wd;

  always_comb begin
    n3     = (n << 1) + n + VAL_ONE;
    idx_ok = 32'(idx) < 32'(NUM_BINS);
    inc    = (rdata == '1) ? rdata : rdata + 32'd1;

    flags.cnt_over   = cnt > MAX_CNT;
    flags.run_go     = (n != VAL_ONE) && !ovf && !(cnt > MAX_CNT);
    flags.sweep_more = sweep != LAST_ADDR;
    flags.is_run     = cmd_r == CMD_RUN;
    flags.is_read    = cmd_r == CMD_READ;
    flags.is_clear   = cmd_r == CMD_CLEAR;
    flags.out_busy   = out_valid && !m_tready;

    mem_re = 1'b0;
    mem_ra = AW'(cnt);
    mem_we = 1'b0;
    mem_wa = AW'(cnt);
    mem_wd = inc;
    if (cmd.fire) begin
      case (cmd.op)
        OP_RD_CNT: begin
          mem_re = !(cnt > MAX_CNT);
        end
        OP_RD_IDX: begin
          mem_re = idx_ok;
          mem_ra = AW'(idx);
        end
        OP_INC_WR: begin
          mem_we = 1'b1;
        end
        OP_CLR_WR: begin
          mem_we = 1'b1;
          mem_wa = sweep;
          mem_wd = '0;
        end
        default: begin
          mem_re = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sweep     <= '0;
      n         <= '0;
      cnt       <= '0;
    end else begin
      if (m_tready && !(cmd.fire && cmd.op == OP_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (cmd.fire) begin
        case (cmd.op)
          OP_ACCEPT: begin
            cmd_r   <= cmd_t'(s_tuser);
            n       <= VW'(s_tdata[START_W-1:0]);
            idx     <= s_tdata[START_W +: INDEX_W];
            cnt     <= '0;
            ovf     <= 1'b0;
            counted <= 1'b0;
            binv    <= '0;
            sweep   <= '0;
          end
          OP_MAP: begin
            if (flags.run_go) begin
              if (!n[0]) begin
                n   <= n >> 1;
                cnt <= cnt + 1'b1;
              end else if (n > ODD_LIMIT) begin
                ovf <= 1'b1;
                cnt <= OVER_CNT;
              end else begin
                n   <= n3;
                cnt <= cnt + 1'b1;
              end
            end
          end
          OP_INC_WR: begin
            counted <= 1'b1;
            binv    <= inc;
          end
          OP_LOAD_BIN: begin
            binv <= idx_ok ? rdata : '0;
          end
          OP_CLR_WR: begin
            sweep <= sweep + 1'b1;
          end
          OP_EMIT: begin
            out_valid <= 1'b1;
            out_data  <= {{OUT_PAD_W{1'b0}}, binv, ovf, counted, STEPS_W'(cnt)};
          end
          default: begin
            sweep <= sweep;
          end
        endcase
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
